// ----- rtl/mqd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_pkg: shared types and constants
// Table size, field widths, status codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package mqd_pkg;

    localparam int ENTRIES    = 16;
    localparam int TIME_WIDTH = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int PID_W      = 8;
    localparam int QNT_W      = 16;

    localparam logic [QNT_W-1:0] QUANTUM_RESET = QNT_W'(2);
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic CLASS_SYSTEM = 1'b0;

    typedef enum logic [1:0] {
        ST_SUBMITTED  = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture input item
        logic scan_clear;  // reset scan accumulators
        logic scan_step;   // examine entry at scan index
        logic mark_due;    // ready every due entry (one entry per step)
        logic jump_time;   // set time to earliest pending key
        logic do_submit;   // store item or report full
        logic do_run;      // run the selected entry
        logic do_empty;    // report nothing left
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dispatch;
        logic found_ready;
        logic found_any;
    } t_sts;

endpackage

// ----- rtl/mqd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_datapath: process table and scan datapath
// Holds the entry table, current time and quantum; scans one entry a cycle.
// ----------------------------------------------------------------------------
module mqd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [15:0]                 i_cfg_data,
    input  logic                        i_opcode,
    input  logic [7:0]                  i_process_id,
    input  logic [15:0]                 i_arrival_time,
    input  logic [15:0]                 i_burst_length,
    input  logic                        i_process_class,
    input  mqd_pkg::t_cmd               i_cmd,
    input  logic [mqd_pkg::IDX_W-1:0]   i_scan_idx,
    output mqd_pkg::t_sts               o_sts,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_run_pid,
    output logic [15:0]                 o_run_length,
    output logic                        o_finished,
    output logic [15:0]                 o_time_after
);
    import mqd_pkg::*;

    logic [ENTRIES-1:0] r_valid, r_ready;
    logic [ENTRIES-1:0] r_class;
    t_time              r_key [ENTRIES];
    logic [PID_W-1:0]   r_pid [ENTRIES];
    t_time              r_rem [ENTRIES];
    t_time              r_time;
    logic [QNT_W-1:0]   r_quantum;

    logic               r_op, r_in_class;
    logic [PID_W-1:0]   r_in_pid;
    t_time              r_in_arr, r_in_burst;

    // scan results
    logic               r_best_ok;
    t_idx               r_best;
    logic               r_free_ok;
    t_idx               r_free;
    logic               r_any;
    t_time              r_earliest;

    logic [1:0]         r_status;
    logic [PID_W-1:0]   r_out_pid;
    t_time              r_out_len;
    logic               r_out_fin;

    logic  e_rdy, e_before;
    t_time q_eff;
    logic [TIME_WIDTH:0] sum_q, sum_r, sum_1, key_sum;
    t_time t_new, run_len, rem_sel;
    logic  fin;

    // Entry is ready now, including one that becomes due in this step.
    assign e_rdy = r_valid[i_scan_idx] &&
                   (r_ready[i_scan_idx] || (i_cmd.mark_due && r_key[i_scan_idx] <= r_time));

    always_comb begin
        e_before = 1'b0;
        if (r_class[i_scan_idx] != r_class[r_best])
            e_before = r_class[i_scan_idx] < r_class[r_best];
        else if (r_key[i_scan_idx] != r_key[r_best])
            e_before = r_key[i_scan_idx] < r_key[r_best];
        else if (r_pid[i_scan_idx] != r_pid[r_best])
            e_before = r_pid[i_scan_idx] < r_pid[r_best];
        else
            e_before = r_rem[i_scan_idx] < r_rem[r_best];
    end

    always_comb begin
        q_eff   = (r_quantum == '0) ? t_time'(1) : t_time'(r_quantum);
        rem_sel = r_rem[r_best];
        sum_q   = {1'b0, r_time} + {1'b0, q_eff};
        sum_r   = {1'b0, r_time} + {1'b0, rem_sel};
        sum_1   = {1'b0, r_time} + (TIME_WIDTH+1)'(1);
        if (r_class[r_best] == CLASS_SYSTEM) begin
            if (rem_sel > q_eff) begin
                run_len = q_eff;
                t_new   = sum_q[TIME_WIDTH] ? TIME_MAX : sum_q[TIME_WIDTH-1:0];
                fin     = 1'b0;
            end else begin
                run_len = rem_sel;
                t_new   = sum_r[TIME_WIDTH] ? TIME_MAX : sum_r[TIME_WIDTH-1:0];
                fin     = 1'b1;
            end
        end else begin
            run_len = t_time'(1);
            t_new   = sum_1[TIME_WIDTH] ? TIME_MAX : sum_1[TIME_WIDTH-1:0];
            fin     = (rem_sel <= t_time'(1));
        end
        key_sum = {1'b0, t_new} + (TIME_WIDTH+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_ready   <= '0;
            r_time    <= '0;
            r_quantum <= QUANTUM_RESET;
        end else begin
            if (i_cfg_we)
                r_quantum <= i_cfg_data;
            if (i_cmd.scan_step && i_cmd.mark_due && e_rdy)
                r_ready[i_scan_idx] <= 1'b1;
            if (i_cmd.jump_time)
                r_time <= r_earliest;
            if (i_cmd.do_submit && r_free_ok) begin
                r_valid[r_free] <= 1'b1;
                r_ready[r_free] <= 1'b0;
            end
            if (i_cmd.do_run) begin
                r_time <= t_new;
                if (fin) begin
                    r_valid[r_best] <= 1'b0;
                    r_ready[r_best] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op       <= i_opcode;
            r_in_pid   <= i_process_id;
            r_in_arr   <= i_arrival_time;
            r_in_burst <= i_burst_length;
            r_in_class <= i_process_class;
        end
        if (i_cmd.scan_clear) begin
            r_best_ok <= 1'b0;
            r_best    <= '0;
            r_free_ok <= 1'b0;
            r_free    <= '0;
            r_any     <= 1'b0;
            r_earliest <= '0;
        end else if (i_cmd.scan_step) begin
            if (!r_valid[i_scan_idx] && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= i_scan_idx;
            end
            if (r_valid[i_scan_idx] && (!r_any || r_key[i_scan_idx] < r_earliest)) begin
                r_any      <= 1'b1;
                r_earliest <= r_key[i_scan_idx];
            end
            if (e_rdy && (!r_best_ok || e_before)) begin
                r_best_ok <= 1'b1;
                r_best    <= i_scan_idx;
            end
        end
        if (i_cmd.do_submit) begin
            r_status  <= r_free_ok ? ST_SUBMITTED : ST_TABLE_FULL;
            r_out_pid <= '0;
            r_out_len <= '0;
            r_out_fin <= 1'b0;
            if (r_free_ok) begin
                r_class[r_free] <= r_in_class;
                r_key[r_free]   <= r_in_arr;
                r_pid[r_free]   <= r_in_pid;
                r_rem[r_free]   <= r_in_burst;
            end
        end
        if (i_cmd.do_empty) begin
            r_status  <= ST_EMPTY;
            r_out_pid <= '0;
            r_out_len <= '0;
            r_out_fin <= 1'b0;
        end
        if (i_cmd.do_run) begin
            r_status  <= ST_DISPATCHED;
            r_out_pid <= r_pid[r_best];
            r_out_len <= run_len;
            r_out_fin <= fin;
            r_rem[r_best] <= fin ? '0 : (rem_sel - run_len);
            if (r_class[r_best] == CLASS_SYSTEM && !fin)
                r_key[r_best] <= key_sum[TIME_WIDTH] ? TIME_MAX : key_sum[TIME_WIDTH-1:0];
        end
    end

    assign o_sts.is_dispatch = (r_op == OP_DISPATCH);
    assign o_sts.found_ready = r_best_ok;
    assign o_sts.found_any   = r_any;
    assign o_status     = r_status;
    assign o_run_pid    = r_out_pid;
    assign o_run_length = 16'(r_out_len);
    assign o_finished   = r_out_fin;
    assign o_time_after = 16'(r_time);

endmodule

// ----- rtl/mqd_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_controller: dispatch sequencer
// Walks the table one entry a cycle and steps the datapath through an item.
// ----------------------------------------------------------------------------
module mqd_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    output logic                        o_valid,
    input  logic                        i_ready,
    input  mqd_pkg::t_sts               i_sts,
    output mqd_pkg::t_cmd               o_cmd,
    output logic [mqd_pkg::IDX_W-1:0]   o_scan_idx
);
    import mqd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RESCAN, S_FINAL, S_OUT
    } t_state;

    t_state r_state;
    t_idx   r_idx;
    logic   r_oval;
    logic   last;

    assign last = (r_idx == t_idx'(ENTRIES - 1));

    always_comb begin
        o_cmd = '0;
        o_cmd.load_item  = (r_state == S_IDLE) && i_valid;
        o_cmd.scan_clear = o_cmd.load_item || (r_state == S_DECIDE && i_sts.is_dispatch
                           && !i_sts.found_ready && i_sts.found_any);
        o_cmd.scan_step  = (r_state == S_SCAN) || (r_state == S_RESCAN);
        o_cmd.mark_due   = o_cmd.scan_step && i_sts.is_dispatch;
        o_cmd.jump_time  = o_cmd.scan_clear && (r_state == S_DECIDE);
        o_cmd.do_submit  = (r_state == S_DECIDE) && !i_sts.is_dispatch;
        o_cmd.do_empty   = (r_state == S_DECIDE) && i_sts.is_dispatch
                           && !i_sts.found_ready && !i_sts.found_any;
        o_cmd.do_run     = ((r_state == S_DECIDE) || (r_state == S_FINAL))
                           && i_sts.is_dispatch && i_sts.found_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_oval  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                    end
                end
                S_SCAN, S_RESCAN: begin
                    r_idx <= r_idx + t_idx'(1);
                    if (last)
                        r_state <= (r_state == S_SCAN) ? S_DECIDE : S_FINAL;
                end
                S_DECIDE: begin
                    if (o_cmd.jump_time) begin
                        r_state <= S_RESCAN;
                        r_idx   <= '0;
                    end else begin
                        r_state <= S_OUT;
                        r_oval  <= 1'b1;
                    end
                end
                S_FINAL: begin
                    r_state <= S_OUT;
                    r_oval  <= 1'b1;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oval  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_oval;
    assign o_scan_idx = r_idx;

endmodule

// ----- rtl/multilevel_queue_dispatcher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_dispatcher_unit: two-class process dispatcher
// Process table with system (round robin) and user (first come) classes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries submit or dispatch items; the
//   output channel (o_valid/i_ready) returns one result per item.
//   The quantum register is written through i_cfg_we/i_cfg_data; the user
//   must write it only while idle, the block itself does not enforce this.
//   Each item walks the table once, one entry per cycle, then passes a
//   decide step before the result is offered. A dispatch that finds no
//   ready entry jumps time to the earliest pending key and walks the table
//   again before its result is offered. One item is in flight at a time.
//   Reset empties the table, clears time and sets the quantum to 2.
//   While the receiver stalls the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module multilevel_queue_dispatcher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_process_id,
    input  logic [15:0] i_arrival_time,
    input  logic [15:0] i_burst_length,
    input  logic        i_process_class,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_run_pid,
    output logic [15:0] o_run_length,
    output logic        o_finished,
    output logic [15:0] o_time_after
);
    import mqd_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_idx scan_idx;

    mqd_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_sts(sts), .o_cmd(cmd), .o_scan_idx(scan_idx)
    );

    mqd_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_process_id(i_process_id),
        .i_arrival_time(i_arrival_time), .i_burst_length(i_burst_length),
        .i_process_class(i_process_class),
        .i_cmd(cmd), .i_scan_idx(scan_idx), .o_sts(sts),
        .o_status(o_status), .o_run_pid(o_run_pid),
        .o_run_length(o_run_length), .o_finished(o_finished),
        .o_time_after(o_time_after)
    );

endmodule

// ----- rtl/mqd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_checker: port-level checks
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module mqd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        i_valid,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_run_length,
    input logic        o_finished,
    input logic [15:0] o_time_after
);
    import mqd_pkg::*;

    // No new item is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");

    // Hold an offered item until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid) else $error("input valid dropped before transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_time_after) && $stable(o_status))
        else $error("stalled result changed");

    // Only a dispatch produces a run or a finish.
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DISPATCHED |-> o_run_length == '0 && !o_finished)
        else $error("run data on non-dispatch result");

    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready && !o_valid)
        else $error("not idle after result transfer");

endmodule

bind multilevel_queue_dispatcher_unit mqd_checker u_mqd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .i_valid(i_valid),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_run_length(o_run_length), .o_finished(o_finished),
    .o_time_after(o_time_after)
);
